@@ sv/lsa_pkg.sv @@
// Shared types, constants and helpers for the LIFO stack allocator.
`default_nettype none
package lsa_pkg;

    // Region geometry
    localparam int OFF_W          = 32;
    localparam int HEADER_BYTES   = 16;
    localparam int STACK_DEPTH    = 64;
    localparam int ALIGN_LOG2_MAX = 15;

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W   = $clog2(STACK_DEPTH);
    localparam int PAD_W   = $clog2(HEADER_BYTES + (2 ** ALIGN_LOG2_MAX)) + 1;
    localparam int END_W   = OFF_W + 2;
    localparam int HDR_W   = 2 * OFF_W + 1;

    localparam int OP_W     = 3;
    localparam int STAT_W   = 3;
    localparam int LG_W     = 4;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC    = 3'd0,
        OP_FREE     = 3'd1,
        OP_RESET    = 3'd2,
        OP_ROLLBACK = 3'd3,
        OP_QUERY    = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_NULL       = 3'd1,
        STAT_NO_SPACE   = 3'd2,
        STAT_NOT_LAST   = 3'd3,
        STAT_BAD_MARKER = 3'd4,
        STAT_STACK_FULL = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDRESS = 1'b0,
        REG_CAPACITY     = 1'b1
    } cfg_reg_t;

    // One header entry: previous top, previous last block and its valid bit
    typedef struct packed {
        logic [OFF_W-1:0] prev_top;
        logic [OFF_W-1:0] prev_last;
        logic             prev_valid;
    } hdr_entry_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic load_pad;
        logic commit;
    } dp_cmd_t;

    // Datapath status to the checks
    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic               last_valid;
    } dp_status_t;

    function automatic logic [OFF_W-1:0] sat_inc(input logic [OFF_W-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

endpackage
`default_nettype wire

@@ sv/lsa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

@@ sv/lsa_ctrl.sv @@
// Sequencing controller: accept, pad calculation, commit and result handoff.
`default_nettype none
module lsa_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output lsa_pkg::dp_cmd_t     cmd
);
    import lsa_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        CALC,
        EXEC
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Next state and commands
    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = CALC;
                end
            end
            CALC: begin
                cmd.load_pad = 1'b1;
                state_next   = EXEC;
            end
            EXEC: begin
                // hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    cmd.commit   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = IDLE;
                end
            end
            default: begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = m_valid_reg;

endmodule
`default_nettype wire

@@ sv/lsa_datapath.sv @@
// Allocator datapath: config registers, region state, header stack and result word.
`default_nettype none
module lsa_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire lsa_pkg::dp_cmd_t              cmd,
    output lsa_pkg::dp_status_t                status,
    input  wire logic                          cfg_wr,
    input  wire logic [lsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lsa_pkg::OFF_W-1:0]     cfg_data,
    input  wire logic [lsa_pkg::OP_W-1:0]      s_operation,
    input  wire logic [lsa_pkg::OFF_W-1:0]     s_request_bytes,
    input  wire logic [lsa_pkg::LG_W-1:0]      s_align_log2,
    input  wire logic [lsa_pkg::OFF_W-1:0]     s_pointer_offset,
    input  wire logic                          s_pointer_is_null,
    input  wire logic [lsa_pkg::OFF_W-1:0]     s_marker,
    output logic      [lsa_pkg::STAT_W-1:0]    m_status,
    output logic      [lsa_pkg::OFF_W-1:0]     m_block_offset,
    output logic      [lsa_pkg::OFF_W-1:0]     m_top_offset,
    output logic      [lsa_pkg::OFF_W-1:0]     m_peak_used,
    output logic      [lsa_pkg::OFF_W-1:0]     m_live_count,
    output logic      [lsa_pkg::OFF_W-1:0]     m_total_allocs,
    output logic      [lsa_pkg::OFF_W-1:0]     m_total_frees,
    output logic      [lsa_pkg::OFF_W-1:0]     m_failed_allocs
);
    import lsa_pkg::*;

    localparam logic [PAD_W-1:0]   HDR_P  = PAD_W'(HEADER_BYTES);
    localparam logic [DEPTH_W-1:0] FULL_D = DEPTH_W'(STACK_DEPTH);

    // Configuration
    logic [OFF_W-1:0] base_reg, cap_reg;

    // Region state
    logic [OFF_W-1:0]   used_reg, used_next;
    logic [OFF_W-1:0]   last_off_reg, last_off_next;
    logic               last_valid_reg, last_valid_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    logic [OFF_W-1:0]   peak_reg, peak_next;
    logic [OFF_W-1:0]   live_reg, live_next;
    logic [OFF_W-1:0]   allocs_reg, allocs_next;
    logic [OFF_W-1:0]   frees_reg, frees_next;
    logic [OFF_W-1:0]   fails_reg, fails_next;

    // Captured item
    logic [OP_W-1:0]  op_reg;
    logic [OFF_W-1:0] req_reg;
    logic [LG_W-1:0]  lg_reg;
    logic [OFF_W-1:0] ptr_reg;
    logic             null_reg;
    logic [OFF_W-1:0] mark_reg;

    // Padding stage
    logic [OFF_W-1:0] addr;
    logic [PAD_W-1:0] align_p, mask_p, mis, adj0, adj, adj_reg;

    // Commit stage
    logic [END_W-1:0]  end_sum;
    logic [OFF_W-1:0]  end_w, blk;
    logic [STAT_W-1:0] status_next;
    logic [OFF_W-1:0]  blk_next;

    // Header stack
    logic [DEPTH_W-1:0] depth_m1;
    hdr_entry_t         ram_wdata, ram_rdata;
    logic               ram_we;

    // Config writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg <= '0;
            cap_reg  <= '0;
        end else if (cfg_wr) begin
            case (cfg_reg_t'(cfg_index))
                REG_BASE_ADDRESS: base_reg <= cfg_data;
                REG_CAPACITY:     cap_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg   <= s_operation;
            req_reg  <= s_request_bytes;
            lg_reg   <= s_align_log2;
            ptr_reg  <= s_pointer_offset;
            null_reg <= s_pointer_is_null;
            mark_reg <= s_marker;
        end
    end

    // Padding to an aligned address with header room in front
    always_comb begin
        addr    = base_reg + used_reg;
        align_p = PAD_W'(1) << lg_reg;
        mask_p  = align_p - 1'b1;
        mis     = addr[PAD_W-1:0] & mask_p;
        adj0    = (align_p - mis) & mask_p;
        adj     = adj0;
        if (adj0 < HDR_P) begin
            adj = adj0 + (((HDR_P - adj0) + mask_p) & ~mask_p);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_pad) begin
            adj_reg <= adj;
        end
    end

    // Header stack: top entry is read continuously, pushed on allocate
    assign depth_m1 = depth_reg - 1'b1;

    lsa_ram #(
        .WIDTH (HDR_W),
        .DEPTH (STACK_DEPTH)
    ) u_hdr_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (depth_reg[IDX_W-1:0]),
        .wr_data (ram_wdata),
        .rd_addr (depth_m1[IDX_W-1:0]),
        .rd_data (ram_rdata)
    );

    // Operation decode and state update
    always_comb begin
        end_sum = {2'b00, used_reg} + {{(END_W-PAD_W){1'b0}}, adj_reg}
                  + {2'b00, req_reg};
        end_w   = end_sum[OFF_W-1:0];
        blk     = used_reg + {{(OFF_W-PAD_W){1'b0}}, adj_reg};

        used_next       = used_reg;
        last_off_next   = last_off_reg;
        last_valid_next = last_valid_reg;
        depth_next      = depth_reg;
        peak_next       = peak_reg;
        live_next       = live_reg;
        allocs_next     = allocs_reg;
        frees_next      = frees_reg;
        fails_next      = fails_reg;
        status_next     = STAT_OK;
        blk_next        = '0;
        ram_we          = 1'b0;
        ram_wdata       = '{prev_top: used_reg, prev_last: last_off_reg,
                            prev_valid: last_valid_reg};

        case (op_t'(op_reg))
            OP_ALLOC: begin
                if (req_reg == '0) begin
                    status_next = STAT_NULL;
                end else if (end_sum > {2'b00, cap_reg}) begin
                    status_next = STAT_NO_SPACE;
                    fails_next  = sat_inc(fails_reg);
                end else if (depth_reg == FULL_D) begin
                    status_next = STAT_STACK_FULL;
                end else begin
                    ram_we          = cmd.commit;
                    depth_next      = depth_reg + 1'b1;
                    blk_next        = blk;
                    used_next       = end_w;
                    last_off_next   = blk;
                    last_valid_next = 1'b1;
                    if (end_w > peak_reg) begin
                        peak_next = end_w;
                    end
                    live_next   = sat_inc(live_reg);
                    allocs_next = sat_inc(allocs_reg);
                end
            end
            OP_FREE: begin
                if (!null_reg) begin
                    if (!last_valid_reg || ptr_reg != last_off_reg || depth_reg == '0) begin
                        status_next = STAT_NOT_LAST;
                    end else begin
                        depth_next      = depth_m1;
                        used_next       = ram_rdata.prev_top;
                        last_off_next   = ram_rdata.prev_last;
                        last_valid_next = ram_rdata.prev_valid;
                        if (live_reg != '0) begin
                            live_next = live_reg - 1'b1;
                        end
                        frees_next = sat_inc(frees_reg);
                    end
                end
            end
            OP_RESET: begin
                used_next       = '0;
                last_off_next   = '0;
                last_valid_next = 1'b0;
                depth_next      = '0;
                live_next       = '0;
            end
            OP_ROLLBACK: begin
                if (mark_reg > used_reg) begin
                    status_next = STAT_BAD_MARKER;
                end else begin
                    used_next       = mark_reg;
                    last_off_next   = '0;
                    last_valid_next = 1'b0;
                    depth_next      = '0;
                end
            end
            default: ;
        endcase
    end

    // Region state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg       <= '0;
            last_off_reg   <= '0;
            last_valid_reg <= 1'b0;
            depth_reg      <= '0;
            peak_reg       <= '0;
            live_reg       <= '0;
            allocs_reg     <= '0;
            frees_reg      <= '0;
            fails_reg      <= '0;
        end else if (cmd.commit) begin
            used_reg       <= used_next;
            last_off_reg   <= last_off_next;
            last_valid_reg <= last_valid_next;
            depth_reg      <= depth_next;
            peak_reg       <= peak_next;
            live_reg       <= live_next;
            allocs_reg     <= allocs_next;
            frees_reg      <= frees_next;
            fails_reg      <= fails_next;
        end
    end

    // Result word
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_status        <= status_next;
            m_block_offset  <= blk_next;
            m_top_offset    <= used_next;
            m_peak_used     <= peak_next;
            m_live_count    <= live_next;
            m_total_allocs  <= allocs_next;
            m_total_frees   <= frees_next;
            m_failed_allocs <= fails_next;
        end
    end

    assign status.depth      = depth_reg;
    assign status.last_valid = last_valid_reg;

endmodule
`default_nettype wire

@@ sv/lifo_stack_allocator_core.sv @@
// Top level of the LIFO stack region allocator.
`default_nettype none
// Hands out aligned blocks from one region, bottom up, with a header in front of
// each block; frees must name the most recent block. After a request word is
// accepted, the CALC state computes the alignment padding from the captured word
// while the top header entry is read from the header-stack RAM (registered read).
// The EXEC state then checks capacity and commits, which registers the result
// word once the result register is free.
// The next request word is accepted in the cycle after the commit, so no new
// word is taken while one is in flight; a result left waiting on m_ready holds
// off the following commit only. The configuration port is always ready and is
// meant to be written while idle.
module lifo_stack_allocator_core (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [lsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [lsa_pkg::OFF_W-1:0]     cfg_data,
    // request channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [lsa_pkg::OP_W-1:0]      s_operation,
    input  wire logic [lsa_pkg::OFF_W-1:0]     s_request_bytes,
    input  wire logic [lsa_pkg::LG_W-1:0]      s_align_log2,
    input  wire logic [lsa_pkg::OFF_W-1:0]     s_pointer_offset,
    input  wire logic                          s_pointer_is_null,
    input  wire logic [lsa_pkg::OFF_W-1:0]     s_marker,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [lsa_pkg::STAT_W-1:0]    m_status,
    output logic      [lsa_pkg::OFF_W-1:0]     m_block_offset,
    output logic      [lsa_pkg::OFF_W-1:0]     m_top_offset,
    output logic      [lsa_pkg::OFF_W-1:0]     m_peak_used,
    output logic      [lsa_pkg::OFF_W-1:0]     m_live_count,
    output logic      [lsa_pkg::OFF_W-1:0]     m_total_allocs,
    output logic      [lsa_pkg::OFF_W-1:0]     m_total_frees,
    output logic      [lsa_pkg::OFF_W-1:0]     m_failed_allocs
);
    import lsa_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    lsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    lsa_datapath u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (dp_status),
        .cfg_wr            (cfg_valid & cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_operation       (s_operation),
        .s_request_bytes   (s_request_bytes),
        .s_align_log2      (s_align_log2),
        .s_pointer_offset  (s_pointer_offset),
        .s_pointer_is_null (s_pointer_is_null),
        .s_marker          (s_marker),
        .m_status          (m_status),
        .m_block_offset    (m_block_offset),
        .m_top_offset      (m_top_offset),
        .m_peak_used       (m_peak_used),
        .m_live_count      (m_live_count),
        .m_total_allocs    (m_total_allocs),
        .m_total_frees     (m_total_frees),
        .m_failed_allocs   (m_failed_allocs)
    );

    // One word in flight: no second accept right after an accept
    a_single_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous word still in flight");

    // A commit always leaves a result word pending
    a_commit_result: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid)
        else $error("commit without result word");

    // Header stack never overflows
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        dp_status.depth <= DEPTH_W'(STACK_DEPTH))
        else $error("header stack depth beyond capacity");

    // An empty header stack implies no last block
    a_empty_no_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (dp_status.depth == '0) |-> !dp_status.last_valid)
        else $error("last block valid with empty header stack");

endmodule
`default_nettype wire

@@ tb/lifo_stack_allocator_core_tb.sv @@
// Self-checking testbench for the LIFO stack allocator core: directed table, then random phases.
`default_nettype none
module lifo_stack_allocator_core_tb;
    import lsa_pkg::*;

    // Operation codes past query; the block treats them as query
    localparam bit [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam bit [OP_W-1:0] OP_SPARE_MID   = 3'd6;
    localparam bit [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    typedef struct {
        bit [OP_W-1:0]  op;
        bit [OFF_W-1:0] bytes;
        bit [LG_W-1:0]  lg;
        bit [OFF_W-1:0] ptr;
        bit             is_null;
        bit [OFF_W-1:0] mark;
    } alloc_req_t;

    typedef struct {
        status_t        status;
        bit [OFF_W-1:0] blk;
        bit [OFF_W-1:0] top;
        bit [OFF_W-1:0] peak;
        bit [OFF_W-1:0] live;
        bit [OFF_W-1:0] allocs;
        bit [OFF_W-1:0] frees;
        bit [OFF_W-1:0] fails;
    } alloc_result_t;

    // One directed row; at_last takes the pointer from the current last block
    typedef struct {
        alloc_req_t req;
        bit         at_last;
        bit         typed;
        status_t    status;
    } plan_row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [OFF_W-1:0]     cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [OP_W-1:0]      s_operation;
    logic [OFF_W-1:0]     s_request_bytes;
    logic [LG_W-1:0]      s_align_log2;
    logic [OFF_W-1:0]     s_pointer_offset;
    logic                 s_pointer_is_null;
    logic [OFF_W-1:0]     s_marker;
    logic                 m_valid;
    logic                 m_ready;
    logic [STAT_W-1:0]    m_status;
    logic [OFF_W-1:0]     m_block_offset;
    logic [OFF_W-1:0]     m_top_offset;
    logic [OFF_W-1:0]     m_peak_used;
    logic [OFF_W-1:0]     m_live_count;
    logic [OFF_W-1:0]     m_total_allocs;
    logic [OFF_W-1:0]     m_total_frees;
    logic [OFF_W-1:0]     m_failed_allocs;

    lifo_stack_allocator_core DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_operation       (s_operation),
        .s_request_bytes   (s_request_bytes),
        .s_align_log2      (s_align_log2),
        .s_pointer_offset  (s_pointer_offset),
        .s_pointer_is_null (s_pointer_is_null),
        .s_marker          (s_marker),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_block_offset    (m_block_offset),
        .m_top_offset      (m_top_offset),
        .m_peak_used       (m_peak_used),
        .m_live_count      (m_live_count),
        .m_total_allocs    (m_total_allocs),
        .m_total_frees     (m_total_frees),
        .m_failed_allocs   (m_failed_allocs)
    );

    // Allocator shadow state
    bit [OFF_W-1:0] cfg_base;
    bit [OFF_W-1:0] cfg_cap;
    bit [OFF_W-1:0] top_used;
    bit [OFF_W-1:0] last_blk;
    bit             last_ok;
    hdr_entry_t     hdr_mem [STACK_DEPTH];
    int             depth;
    bit [OFF_W-1:0] peak;
    bit [OFF_W-1:0] live;
    bit [OFF_W-1:0] n_alloc;
    bit [OFF_W-1:0] n_free;
    bit [OFF_W-1:0] n_fail;

    alloc_result_t expected_q[$];
    plan_row_t     directed_plan[$];
    int            mismatches;
    int            sender_idle_pct;
    int            recv_stall_pct;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit [OFF_W-1:0] bump(input bit [OFF_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Padding from addr to an aligned address with a full header in front of it
    function automatic bit [END_W-1:0] header_pad(input bit [OFF_W-1:0] addr,
                                                  input bit [LG_W-1:0] lg);
        bit [END_W-1:0] align;
        bit [END_W-1:0] mis;
        bit [END_W-1:0] adj;
        bit [END_W-1:0] need;
        align = {{(END_W-1){1'b0}}, 1'b1} << lg;
        mis   = {2'b00, addr} & (align - 1'b1);
        adj   = (mis != 0) ? align - mis : '0;
        if (adj < HEADER_BYTES) begin
            need = HEADER_BYTES - adj;
            adj  = adj + align * (need / align);
            if (need % align != 0)
                adj = adj + align;
        end
        return adj;
    endfunction

    // Applies one request word to the shadow state, returns the expected result word
    function automatic alloc_result_t step_allocator(input alloc_req_t r);
        alloc_result_t  res;
        bit [OFF_W-1:0] addr;
        bit [END_W-1:0] pad;
        bit [END_W-1:0] fin;
        res.status = STAT_OK;
        res.blk    = '0;
        case (r.op)
            OP_ALLOC: begin
                if (r.bytes == 0) begin
                    res.status = STAT_NULL;
                end else begin
                    addr = cfg_base + top_used;
                    pad  = header_pad(addr, r.lg);
                    fin  = {2'b00, top_used} + pad + {2'b00, r.bytes};
                    if (fin > {2'b00, cfg_cap}) begin
                        res.status = STAT_NO_SPACE;
                        n_fail = bump(n_fail);
                    end else if (depth >= STACK_DEPTH) begin
                        res.status = STAT_STACK_FULL;
                    end else begin
                        hdr_mem[depth].prev_top   = top_used;
                        hdr_mem[depth].prev_last  = last_blk;
                        hdr_mem[depth].prev_valid = last_ok;
                        depth++;
                        res.blk  = top_used + pad[OFF_W-1:0];
                        top_used = fin[OFF_W-1:0];
                        last_blk = res.blk;
                        last_ok  = 1'b1;
                        if (top_used > peak)
                            peak = top_used;
                        live    = bump(live);
                        n_alloc = bump(n_alloc);
                    end
                end
            end
            OP_FREE: begin
                if (!r.is_null) begin
                    if (!last_ok || r.ptr != last_blk || depth == 0) begin
                        res.status = STAT_NOT_LAST;
                    end else begin
                        depth--;
                        top_used = hdr_mem[depth].prev_top;
                        last_blk = hdr_mem[depth].prev_last;
                        last_ok  = hdr_mem[depth].prev_valid;
                        if (live != 0)
                            live--;
                        n_free = bump(n_free);
                    end
                end
            end
            OP_RESET: begin
                top_used = '0;
                last_blk = '0;
                last_ok  = 1'b0;
                depth    = 0;
                live     = '0;
            end
            OP_ROLLBACK: begin
                if (r.mark > top_used) begin
                    res.status = STAT_BAD_MARKER;
                end else begin
                    top_used = r.mark;
                    last_blk = '0;
                    last_ok  = 1'b0;
                    depth    = 0;
                end
            end
            default: ;
        endcase
        res.top    = top_used;
        res.peak   = peak;
        res.live   = live;
        res.allocs = n_alloc;
        res.frees  = n_free;
        res.fails  = n_fail;
        return res;
    endfunction

    function automatic plan_row_t plan_row(input bit [OP_W-1:0] op, input bit [OFF_W-1:0] bytes,
                                           input bit [LG_W-1:0] lg, input bit [OFF_W-1:0] ptr,
                                           input bit is_null, input bit [OFF_W-1:0] mark,
                                           input bit at_last, input bit typed,
                                           input status_t st);
        plan_row_t row;
        row.req.op      = op;
        row.req.bytes   = bytes;
        row.req.lg      = lg;
        row.req.ptr     = ptr;
        row.req.is_null = is_null;
        row.req.mark    = mark;
        row.at_last     = at_last;
        row.typed       = typed;
        row.status      = st;
        return row;
    endfunction

    // Random request word; mostly well-formed against the shadow state
    function automatic alloc_req_t make_request(input bit fill, input bit [OFF_W-1:0] small_max);
        alloc_req_t r;
        int         p;
        r.bytes   = $urandom;
        r.lg      = LG_W'($urandom);
        r.ptr     = $urandom;
        r.is_null = 1'($urandom);
        r.mark    = $urandom;
        p = $urandom_range(99);
        if (fill)
            r.op = (p < 90) ? OP_ALLOC : (p < 96) ? OP_FREE : OP_QUERY;
        else if (p < 45) r.op = OP_ALLOC;
        else if (p < 75) r.op = OP_FREE;
        else if (p < 84) r.op = OP_ROLLBACK;
        else if (p < 88) r.op = OP_RESET;
        else if (p < 94) r.op = OP_QUERY;
        else r.op = OP_W'($urandom_range(OP_SPARE_LAST, OP_SPARE_FIRST));
        case (r.op)
            OP_ALLOC: begin
                p = $urandom_range(99);
                if (p < 6)
                    r.bytes = '0;
                else if (p >= 14)
                    r.bytes = $urandom_range(small_max, 1);
                if ($urandom_range(99) >= 30)
                    r.lg = LG_W'($urandom_range(6, 0));
            end
            OP_FREE: begin
                r.is_null = ($urandom_range(99) < 10);
                if (last_ok && $urandom_range(99) < 80)
                    r.ptr = last_blk;
            end
            OP_ROLLBACK: begin
                p = $urandom_range(99);
                if (p < 10)
                    r.mark = top_used;
                else if (p < 80)
                    r.mark = $urandom_range(top_used, 0);
            end
            default: ;
        endcase
        return r;
    endfunction

    // Drive one request word, hold it until accepted, then predict its result
    task automatic issue(input alloc_req_t r, input bit typed, input status_t typed_st);
        alloc_result_t exp;
        int            gap;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_operation       <= r.op;
        s_request_bytes   <= r.bytes;
        s_align_log2      <= r.lg;
        s_pointer_offset  <= r.ptr;
        s_pointer_is_null <= r.is_null;
        s_marker          <= r.mark;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        exp = step_allocator(r);
        if (typed)
            exp.status = typed_st;
        expected_q.push_back(exp);
    endtask

    // Stop sending, wait for every result word, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input bit [OFF_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        if (idx == REG_BASE_ADDRESS)
            cfg_base = val;
        else
            cfg_cap = val;
    endtask

    task automatic configure(input bit [OFF_W-1:0] base, input bit [OFF_W-1:0] cap);
        settle();
        write_reg(REG_BASE_ADDRESS, base);
        write_reg(REG_CAPACITY, cap);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(input bit fill, input bit [OFF_W-1:0] small_max, input int count);
        for (int i = 0; i < count; i++)
            issue(make_request(fill, small_max), 1'b0, STAT_OK);
    endtask

    task automatic compare(input string name, input logic [OFF_W-1:0] want,
                           input logic [OFF_W-1:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h, got %h", name, want, got);
        end
    endtask

    task automatic check_result();
        alloc_result_t exp;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result word with nothing pending, status %h", m_status);
            return;
        end
        exp = expected_q.pop_front();
        compare("status", OFF_W'(exp.status), OFF_W'(m_status));
        compare("block_offset", exp.blk, m_block_offset);
        compare("top_offset", exp.top, m_top_offset);
        compare("peak_used", exp.peak, m_peak_used);
        compare("live_count", exp.live, m_live_count);
        compare("total_allocs", exp.allocs, m_total_allocs);
        compare("total_frees", exp.frees, m_total_frees);
        compare("failed_allocs", exp.fails, m_failed_allocs);
    endtask

    // Result side: check accepted words, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            check_result();
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        plan_row_t      row;
        bit [OFF_W-1:0] cap;
        mismatches      = 0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        cfg_base = '0;
        cfg_cap  = '0;
        top_used = '0;
        last_blk = '0;
        last_ok  = 1'b0;
        depth    = 0;
        peak     = '0;
        live     = '0;
        n_alloc  = '0;
        n_free   = '0;
        n_fail   = '0;

        aresetn           <= 1'b0;
        cfg_valid         <= 1'b0;
        cfg_index         <= REG_BASE_ADDRESS;
        cfg_data          <= '0;
        s_valid           <= 1'b0;
        s_operation       <= OP_QUERY;
        s_request_bytes   <= '0;
        s_align_log2      <= '0;
        s_pointer_offset  <= '0;
        s_pointer_is_null <= 1'b0;
        s_marker          <= '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty state, error codes, alignment, exact fit, spare op codes
        directed_plan.push_back(plan_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 1, STAT_OK));
        directed_plan.push_back(plan_row(OP_ALLOC, 0, 4, 0, 0, 0, 0, 1, STAT_NULL));
        directed_plan.push_back(plan_row(OP_FREE, 0, 0, 0, 0, 0, 0, 1, STAT_NOT_LAST));
        directed_plan.push_back(plan_row(OP_ROLLBACK, 0, 0, 0, 0, 1, 0, 1, STAT_BAD_MARKER));
        directed_plan.push_back(plan_row(OP_ALLOC, '1, 0, 0, 0, 0, 0, 1, STAT_NO_SPACE));
        directed_plan.push_back(plan_row(OP_ALLOC, 32, 0, 0, 0, 0, 0, 0, STAT_OK));
        directed_plan.push_back(plan_row(OP_ALLOC, 8, 4, 0, 0, 0, 0, 0, STAT_OK));
        directed_plan.push_back(plan_row(OP_ALLOC, 1, 15, 0, 0, 0, 0, 1, STAT_NO_SPACE));
        directed_plan.push_back(plan_row(OP_ALLOC, 16, 3, 0, 0, 0, 0, 0, STAT_OK));
        directed_plan.push_back(plan_row(OP_FREE, 0, 0, '1, 1, 0, 0, 1, STAT_OK));
        directed_plan.push_back(plan_row(OP_FREE, 0, 0, '1, 0, 0, 0, 1, STAT_NOT_LAST));
        directed_plan.push_back(plan_row(OP_FREE, 0, 0, 0, 0, 0, 1, 0, STAT_OK));
        directed_plan.push_back(plan_row(OP_FREE, 0, 0, 0, 0, 0, 1, 0, STAT_OK));
        directed_plan.push_back(plan_row(OP_ALLOC, 200, 6, 0, 0, 0, 0, 0, STAT_OK));
        directed_plan.push_back(plan_row(OP_ROLLBACK, 0, 0, 0, 0, '1, 0, 1, STAT_BAD_MARKER));
        directed_plan.push_back(plan_row(OP_ROLLBACK, 0, 0, 0, 0, 40, 0, 0, STAT_OK));
        directed_plan.push_back(plan_row(OP_FREE, 0, 0, 0, 0, 0, 1, 1, STAT_NOT_LAST));
        directed_plan.push_back(plan_row(OP_ALLOC, 1, 2, 0, 0, 0, 0, 0, STAT_OK));
        directed_plan.push_back(plan_row(OP_RESET, 0, 0, 0, 0, 0, 0, 1, STAT_OK));
        directed_plan.push_back(plan_row(OP_SPARE_FIRST, 0, 0, 0, 0, 0, 0, 1, STAT_OK));
        directed_plan.push_back(plan_row(OP_SPARE_MID, 0, 0, 0, 0, 0, 0, 1, STAT_OK));
        directed_plan.push_back(plan_row(OP_SPARE_LAST, '1, '1, '1, 1, '1, 0, 1, STAT_OK));
        directed_plan.push_back(plan_row(OP_ALLOC, 496, 0, 0, 0, 0, 0, 0, STAT_OK));
        directed_plan.push_back(plan_row(OP_ALLOC, 1, 0, 0, 0, 0, 0, 1, STAT_NO_SPACE));
        directed_plan.push_back(plan_row(OP_ROLLBACK, 0, 0, 0, 0, 512, 0, 0, STAT_OK));

        configure(32'h0000_1000, 512);
        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.at_last)
                row.req.ptr = last_blk;
            issue(row.req, row.typed, row.status);
        end

        // Random phases across register settings and idle patterns
        sender_idle_pct = 51;
        recv_stall_pct  = 0;
        configure('0, '0);
        run_random(0, 16, 40);

        sender_idle_pct = 0;
        recv_stall_pct  = 51;
        configure(32'hFFFF_FFF0, 4096);
        run_random(0, 200, 110);

        // Alloc-heavy with the largest capacity: drives the header stack to full
        sender_idle_pct = 18;
        recv_stall_pct  = 18;
        configure($urandom, '1);
        run_random(1, 64, 120);

        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        configure('1, 65536);
        run_random(0, 3000, 110);

        sender_idle_pct = 51;
        recv_stall_pct  = 51;
        cap = $urandom_range(8192, 256);
        configure($urandom, cap);
        run_random(0, cap / 8 + 1, 120);

        settle();
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
`default_nettype wire
